### sv/ktp_pkg.sv
// ktp_pkg: shared types, constants and the exp step table of the
// keystate transition probability pipeline; no dependencies
`timescale 1ns / 1ps
package ktp_pkg;

  localparam int EXP_BITS  = 21;
  localparam int Y_DIV_W   = 12;
  localparam int Q_DIV_W   = 34;
  localparam int Q_BITS    = 17;
  localparam int Y_STEP    = 3;
  localparam int Q_STEP    = 2;
  localparam int OUT_W     = 17;
  localparam int SCALE_W   = 30;
  localparam int SHAPE_W   = 16;
  localparam int CFG_W     = 30;
  localparam int CFG_IDX_W = 2;

  localparam logic [OUT_W-1:0] OUT_ONE = 17'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_TABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_MARK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_WORD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_PAUSE = 2'd3;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 30'd477201505;
  localparam logic [SHAPE_W-1:0] SHAPE_RESET = 16'd256;

  localparam logic [2:0] ELEM_DIT   = 3'd1;
  localparam logic [2:0] ELEM_DAH   = 3'd2;
  localparam logic [2:0] ELEM_ESP   = 3'd3;
  localparam logic [2:0] ELEM_CSP   = 3'd4;
  localparam logic [2:0] ELEM_WORD  = 3'd5;
  localparam logic [2:0] ELEM_PAUSE = 3'd6;

  typedef enum logic [1:0] {
    SPAN_BELOW,
    SPAN_CROSS,
    SPAN_ABOVE
  } span_t;

  typedef struct packed {
    logic                sat;
    logic [Y_DIV_W-1:0]  rem;
    logic [EXP_BITS-1:0] low;
  } ylane_t;

  typedef struct packed {
    span_t            span;
    logic             sat;
    logic [OUT_W-1:0] res_above;
  } qside_t;

  // t for bit idx: exp(-2^(idx-16)) in q0.32, rounded square chain
  function automatic logic [31:0] exp_step(input int unsigned idx);
    logic [63:0] t;
    t = 64'd4294901760;
    for (int unsigned k = 0; k < idx; k++) begin
      t = (t * t + 64'h8000_0000) >> 32;
    end
    return t[31:0];
  endfunction

endpackage

### sv/ktp_front.sv
// ktp_front: four-stage front end, products, span select, exponent numerator
// and overflow check; depends on ktp_pkg
`timescale 1ns / 1ps
module ktp_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         vld_i,
  input  logic [2:0]                   element_type,
  input  logic [15:0]                  duration,
  input  logic [6:0]                   data_rate,
  input  logic [ktp_pkg::SCALE_W-1:0]  scale_table,
  input  logic [ktp_pkg::SHAPE_W-1:0]  shape_mark,
  input  logic [ktp_pkg::SHAPE_W-1:0]  shape_word,
  input  logic [ktp_pkg::SHAPE_W-1:0]  shape_pause,
  output logic                         vld_o,
  output ktp_pkg::span_t               span_o,
  output logic [ktp_pkg::Y_DIV_W-1:0]  div_o,
  output ktp_pkg::ylane_t              lane_a_o,
  output ktp_pkg::ylane_t              lane_b_o
);
  import ktp_pkg::*;

  logic        v1_r, v2_r, v3_r, v4_r;
  logic [4:0]  ms, ms1;
  logic [22:0] n0_nxt, n1_nxt;
  logic [15:0] d_nxt;
  logic [19:0] a_nxt;
  logic [11:0] c_nxt;
  logic [16:0] dur5;

  logic [22:0] n0_r, n1_r;
  logic [15:0] d_r;
  logic [19:0] a1_r, a2_r;
  logic [11:0] c1_r, c2_r, c3_r, c4_r;

  span_t       span_nxt, span2_r, span3_r, span4_r;
  logic [22:0] da_nxt, db_nxt, da_r, db_r;
  logic [22:0] d_ext;
  logic [42:0] pa_r, pb_r, thr;
  ylane_t      la_nxt, lb_nxt, la_r, lb_r;

  // stage 1: scale lookup and products
  always_comb begin
    case (element_type)
      ELEM_DAH:   ms = scale_table[9:5];
      ELEM_ESP:   ms = scale_table[14:10];
      ELEM_CSP:   ms = scale_table[19:15];
      ELEM_WORD:  ms = scale_table[24:20];
      ELEM_PAUSE: ms = scale_table[29:25];
      default:    ms = scale_table[4:0];
    endcase
    ms1    = (ms == 5'd0) ? 5'd1 : ms;
    d_nxt  = 16'({11'd0, ms1} * 16'd1200);
    n0_nxt = {7'd0, duration} * {16'd0, data_rate};
    dur5   = {1'b0, duration} + 17'd5;
    n1_nxt = {6'd0, dur5} * {16'd0, data_rate};
    case (element_type)
      ELEM_PAUSE: begin
        a_nxt = {4'd0, shape_pause} * 20'd14;
        c_nxt = {7'd0, ms1} * 12'd75;
      end
      ELEM_WORD: begin
        a_nxt = {4'd0, shape_word} * 20'd7;
        c_nxt = {7'd0, ms1} * 12'd75;
      end
      default: begin
        a_nxt = {4'd0, shape_mark};
        c_nxt = 12'd75;
      end
    endcase
  end

  // stage 2: span and differences
  always_comb begin
    d_ext = {7'd0, d_r};
    if (n1_r <= d_ext) begin
      span_nxt = SPAN_BELOW;
      da_nxt   = d_ext - n1_r;
      db_nxt   = d_ext - n0_r;
    end else if (n0_r < d_ext) begin
      span_nxt = SPAN_CROSS;
      da_nxt   = n1_r - d_ext;
      db_nxt   = d_ext - n0_r;
    end else begin
      span_nxt = SPAN_ABOVE;
      da_nxt   = n1_r - n0_r;
      db_nxt   = '0;
    end
  end

  // stage 4: overflow of exponent and divider seed
  always_comb begin
    thr        = {14'd0, c3_r, 17'd0};
    la_nxt.sat = (pa_r >= thr);
    la_nxt.rem = la_nxt.sat ? '0 : pa_r[28:17];
    la_nxt.low = {pa_r[16:0], 4'd0};
    lb_nxt.sat = (pb_r >= thr);
    lb_nxt.rem = lb_nxt.sat ? '0 : pb_r[28:17];
    lb_nxt.low = {pb_r[16:0], 4'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n0_r    <= n0_nxt;
      n1_r    <= n1_nxt;
      d_r     <= d_nxt;
      a1_r    <= a_nxt;
      c1_r    <= c_nxt;
      span2_r <= span_nxt;
      da_r    <= da_nxt;
      db_r    <= db_nxt;
      a2_r    <= a1_r;
      c2_r    <= c1_r;
      pa_r    <= {23'd0, a2_r} * {20'd0, da_r};
      pb_r    <= {23'd0, a2_r} * {20'd0, db_r};
      span3_r <= span2_r;
      c3_r    <= c2_r;
      la_r    <= la_nxt;
      lb_r    <= lb_nxt;
      span4_r <= span3_r;
      c4_r    <= c3_r;
    end
  end

  assign vld_o    = v4_r;
  assign span_o   = span4_r;
  assign div_o    = c4_r;
  assign lane_a_o = la_r;
  assign lane_b_o = lb_r;

endmodule

### sv/ktp_sdiv.sv
// ktp_sdiv: pipelined restoring divider, BPS quotient bits per stage,
// with a sideband that travels alongside; depends on ktp_pkg
`timescale 1ns / 1ps
module ktp_sdiv #(
  parameter int QW  = ktp_pkg::EXP_BITS,
  parameter int DW  = ktp_pkg::Y_DIV_W,
  parameter int BPS = ktp_pkg::Y_STEP,
  parameter int SW  = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] low_i,
  input  logic [DW-1:0] div_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);
  import ktp_pkg::*;

  localparam int NS = (QW + BPS - 1) / BPS;

  logic          vld_r  [NS];
  logic [DW-1:0] rem_r  [NS];
  logic [QW-1:0] quo_r  [NS];
  logic [QW-1:0] low_r  [NS];
  logic [DW-1:0] div_r  [NS];
  logic [SW-1:0] side_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_st
    logic          pv;
    logic [DW-1:0] prem, pdiv;
    logic [QW-1:0] pquo, plow;
    logic [SW-1:0] pside;
    logic [DW-1:0] rem_nxt;
    logic [QW-1:0] quo_nxt;

    if (s == 0) begin : g_src
      assign pv    = vld_i;
      assign prem  = rem_i;
      assign pquo  = '0;
      assign plow  = low_i;
      assign pdiv  = div_i;
      assign pside = side_i;
    end else begin : g_src
      assign pv    = vld_r[s-1];
      assign prem  = rem_r[s-1];
      assign pquo  = quo_r[s-1];
      assign plow  = low_r[s-1];
      assign pdiv  = div_r[s-1];
      assign pside = side_r[s-1];
    end

    always_comb begin
      logic [DW:0] t;
      t       = '0;
      rem_nxt = prem;
      quo_nxt = pquo;
      for (int j = 0; j < BPS; j++) begin
        if (s * BPS + j < QW) begin
          t = {rem_nxt, plow[QW-1-s*BPS-j]};
          if (t >= {1'b0, pdiv}) begin
            t = t - {1'b0, pdiv};
            quo_nxt[QW-1-s*BPS-j] = 1'b1;
          end
          rem_nxt = t[DW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        quo_r[s]  <= quo_nxt;
        low_r[s]  <= plow;
        div_r[s]  <= pdiv;
        side_r[s] <= pside;
      end
    end
  end

  assign vld_o  = vld_r[NS-1];
  assign quo_o  = quo_r[NS-1];
  assign side_o = side_r[NS-1];

endmodule

### sv/ktp_nexp.sv
// ktp_nexp: exp(-y) in q1.32, or zero when zero_i is set, one rounded multiply
// per exponent bit, one bit per stage; depends on ktp_pkg
`timescale 1ns / 1ps
module ktp_nexp #(
  parameter int SW = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic [ktp_pkg::EXP_BITS-1:0]  y_i,
  input  logic                          zero_i,
  input  logic [SW-1:0]                 side_i,
  output logic                          vld_o,
  output logic [32:0]                   e_o,
  output logic [SW-1:0]                 side_o
);
  import ktp_pkg::*;

  logic                vld_r  [EXP_BITS];
  logic [32:0]         r_r    [EXP_BITS];
  logic [EXP_BITS-1:0] y_r    [EXP_BITS];
  logic                zero_r [EXP_BITS];
  logic [SW-1:0]       side_r [EXP_BITS];

  for (genvar i = 0; i < EXP_BITS; i++) begin : g_st
    localparam logic [31:0] STEP = exp_step(i);
    logic                pv, pz;
    logic [32:0]         pr;
    logic [EXP_BITS-1:0] py;
    logic [SW-1:0]       pside;
    logic [65:0]         prod;
    logic [32:0]         r_nxt;

    if (i == 0) begin : g_src
      assign pv    = vld_i;
      assign pr    = 33'h1_0000_0000;
      assign py    = y_i;
      assign pz    = zero_i;
      assign pside = side_i;
    end else begin : g_src
      assign pv    = vld_r[i-1];
      assign pr    = r_r[i-1];
      assign py    = y_r[i-1];
      assign pz    = zero_r[i-1];
      assign pside = side_r[i-1];
    end

    always_comb begin
      prod  = ({33'd0, pr} * {34'd0, STEP}) + 66'h8000_0000;
      r_nxt = py[i] ? prod[64:32] : pr;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[i]    <= r_nxt;
        y_r[i]    <= py;
        zero_r[i] <= pz;
        side_r[i] <= pside;
      end
    end
  end

  assign vld_o  = vld_r[EXP_BITS-1];
  assign e_o    = zero_r[EXP_BITS-1] ? 33'd0 : r_r[EXP_BITS-1];
  assign side_o = side_r[EXP_BITS-1];

endmodule

### sv/keystate_transition_prob.sv
// keystate_transition_prob: top level, config registers, ratio setup and
// output register; depends on ktp_pkg, ktp_front, ktp_sdiv, ktp_nexp
//
//   channel  handshake          payload
//   in       in_valid/in_stall  in_element_type, in_duration, in_data_rate
//   out      out_valid/out_stall out_stay_probability
//   cfg      cfg_we             cfg_index, cfg_data
//
// one transfer per cycle in and out while the output is not stalled; stages with default steps:
// front end 4, exponent divider 7, exp multiply chain 21, ratio setup 1,
// ratio divider 9, output register 1
// reset is synchronous: clears all valid bits and loads the config defaults
// a stalled output freezes the whole pipeline, so nothing is lost or repeated
`timescale 1ns / 1ps
module keystate_transition_prob #(
  parameter int Y_STEP_BITS = ktp_pkg::Y_STEP,
  parameter int Q_STEP_BITS = ktp_pkg::Q_STEP
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_element_type,
  input  logic [15:0]                   in_duration,
  input  logic [6:0]                    in_data_rate,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ktp_pkg::OUT_W-1:0]     out_stay_probability,
  input  logic                          cfg_we,
  input  logic [ktp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ktp_pkg::CFG_W-1:0]     cfg_data
);
  import ktp_pkg::*;

  logic                en;
  logic [SCALE_W-1:0]  scale_table_r;
  logic [SHAPE_W-1:0]  shape_mark_r, shape_word_r, shape_pause_r;

  logic                f_vld;
  span_t               f_span;
  logic [Y_DIV_W-1:0]  f_div;
  ylane_t              f_la, f_lb;

  logic                ya_vld, yb_vld;
  logic [EXP_BITS-1:0] ya_q, yb_q;
  logic [2:0]          ya_side;
  logic [2:0]          yb_side;

  logic                ea_vld, eb_vld;
  logic [32:0]         ea, eb;
  logic [1:0]          ea_side, eb_side;

  logic [33:0]         num, den;
  logic [49:0]         nq;
  logic [50:0]         lim;
  qside_t              qs_nxt;
  logic                r0_vld_r;
  logic [Q_DIV_W-1:0]  r0_rem_r, r0_den_r, rem_nxt;
  logic [Q_BITS-1:0]   r0_low_r;
  qside_t              r0_side_r;

  logic                q_vld;
  logic [Q_BITS-1:0]   q_quo;
  logic [$bits(qside_t)-1:0] q_side_raw;
  qside_t              q_side;

  logic                out_valid_r;
  logic [OUT_W-1:0]    out_prob_r, out_prob_nxt;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_table_r <= SCALE_RESET;
      shape_mark_r  <= SHAPE_RESET;
      shape_word_r  <= SHAPE_RESET;
      shape_pause_r <= SHAPE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE_TABLE: scale_table_r <= cfg_data[SCALE_W-1:0];
        REG_SHAPE_MARK:  shape_mark_r  <= cfg_data[SHAPE_W-1:0];
        REG_SHAPE_WORD:  shape_word_r  <= cfg_data[SHAPE_W-1:0];
        REG_SHAPE_PAUSE: shape_pause_r <= cfg_data[SHAPE_W-1:0];
        default: ;
      endcase
    end
  end

  ktp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .vld_i        (in_valid),
    .element_type (in_element_type),
    .duration     (in_duration),
    .data_rate    (in_data_rate),
    .scale_table  (scale_table_r),
    .shape_mark   (shape_mark_r),
    .shape_word   (shape_word_r),
    .shape_pause  (shape_pause_r),
    .vld_o        (f_vld),
    .span_o       (f_span),
    .div_o        (f_div),
    .lane_a_o     (f_la),
    .lane_b_o     (f_lb)
  );

  ktp_sdiv #(.QW(EXP_BITS), .DW(Y_DIV_W), .BPS(Y_STEP_BITS), .SW(3)) u_ydiv_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (f_vld),
    .rem_i  (f_la.rem),
    .low_i  (f_la.low),
    .div_i  (f_div),
    .side_i ({f_span, f_la.sat}),
    .vld_o  (ya_vld),
    .quo_o  (ya_q),
    .side_o (ya_side)
  );

  ktp_sdiv #(.QW(EXP_BITS), .DW(Y_DIV_W), .BPS(Y_STEP_BITS), .SW(3)) u_ydiv_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (f_vld),
    .rem_i  (f_lb.rem),
    .low_i  (f_lb.low),
    .div_i  (f_div),
    .side_i ({f_span, f_lb.sat}),
    .vld_o  (yb_vld),
    .quo_o  (yb_q),
    .side_o (yb_side)
  );

  ktp_nexp #(.SW(2)) u_exp_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (ya_vld),
    .y_i    (ya_q),
    .zero_i (ya_side[0]),
    .side_i (ya_side[2:1]),
    .vld_o  (ea_vld),
    .e_o    (ea),
    .side_o (ea_side)
  );

  ktp_nexp #(.SW(2)) u_exp_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (yb_vld),
    .y_i    (yb_q),
    .zero_i (yb_side[0]),
    .side_i (yb_side[2:1]),
    .vld_o  (eb_vld),
    .e_o    (eb),
    .side_o (eb_side)
  );

  // ratio setup: num, den, rounding offset, saturation check and above-span result
  always_comb begin
    qs_nxt.span = span_t'(ea_side);
    case (qs_nxt.span)
      SPAN_BELOW: begin
        num = 34'h2_0000_0000 - {1'b0, ea};
        den = 34'h2_0000_0000 - {1'b0, eb};
      end
      SPAN_CROSS: begin
        num = {1'b0, ea};
        den = 34'h2_0000_0000 - {1'b0, eb};
      end
      default: begin
        num = '0;
        den = 34'h2_0000_0000;
      end
    endcase
    nq               = {num, 16'd0} + {17'd0, den[33:1]};
    lim              = {1'b0, den, 16'd0} + {17'd0, den};
    qs_nxt.sat       = ({1'b0, nq} >= lim);
    qs_nxt.res_above = 17'(({1'b0, ea} + 34'd32768) >> 16);
    rem_nxt          = qs_nxt.sat ? '0 : {1'b0, nq[49:17]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r0_vld_r <= 1'b0;
    end else if (en) begin
      r0_vld_r <= ea_vld && eb_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0_rem_r  <= rem_nxt;
      r0_low_r  <= nq[16:0];
      r0_den_r  <= den;
      r0_side_r <= qs_nxt;
    end
  end

  ktp_sdiv #(.QW(Q_BITS), .DW(Q_DIV_W), .BPS(Q_STEP_BITS), .SW($bits(qside_t))) u_qdiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (r0_vld_r),
    .rem_i  (r0_rem_r),
    .low_i  (r0_low_r),
    .div_i  (r0_den_r),
    .side_i (r0_side_r),
    .vld_o  (q_vld),
    .quo_o  (q_quo),
    .side_o (q_side_raw)
  );

  assign q_side = qside_t'(q_side_raw);

  always_comb begin
    if (q_side.span == SPAN_ABOVE) begin
      out_prob_nxt = q_side.res_above;
    end else if (q_side.sat) begin
      out_prob_nxt = OUT_ONE;
    end else begin
      out_prob_nxt = q_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_prob_r <= out_prob_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_stay_probability = out_prob_r;

`ifndef SYNTHESIS
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (ea_vld == eb_vld) && (!ea_vld || ea_side == eb_side))
    else $error("exp lanes out of step");

  a_den_floor: assert property (@(posedge clk) disable iff (!rst_n)
    r0_vld_r |-> (r0_den_r[33:32] != 2'b00))
    else $error("ratio denominator below one");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_prob_r <= OUT_ONE))
    else $error("probability above one");

  a_cfg_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == REG_SHAPE_MARK) |=> (shape_mark_r == $past(cfg_data[15:0])))
    else $error("shape mark write lost");
`endif

endmodule
